// ----- hdl/adm_pkg.sv -----
// Shared constants and types for the arcade drive mixer.
package adm_pkg;

    // Field widths
    localparam int AXIS_W    = 8;     // joystick axis word
    localparam int OUT_W     = 8;     // motor command word
    localparam int CW_W      = 9;     // curve weight register
    localparam int DB_W      = 8;     // deadband register
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 9;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_WEIGHT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 1'd1;

    // Scale: full deflection and its square
    localparam int FULL_SCALE = 127;
    localparam int F2         = FULL_SCALE * FULL_SCALE;
    localparam int F2_W       = 14;
    localparam logic [F2_W-1:0] F2_V = F2_W'(F2);

    // Curve weight of 1.0
    localparam logic [CW_W-1:0] CW_ONE = 9'd256;

    // Shaper datapath widths
    localparam int MAG_W  = 8;        // axis magnitude, 0..130
    localparam int A2_W   = 15;       // a^2
    localparam int A3_W   = 22;       // a^3
    localparam int LIN_W  = 21;       // a * F^2
    localparam int PROD_W = 30;       // weighted terms
    localparam int SHAPE_SHIFT = 8;   // divide by 256 of the weight
    localparam int Y_W    = 22;       // numerator after the shift

    // Rounding offset: half of 256*F^2
    localparam logic [PROD_W:0] HALF_DEN_V = (PROD_W+1)'((256 * F2) / 2);

    // Exact reciprocal of F^2 for Y_W-bit numerators
    localparam int RECIP_S = 37;
    localparam int K_W     = 24;
    localparam longint unsigned RECIP_K_L =
        ((64'd1 << RECIP_S) + longint'(F2) - 1) / longint'(F2);
    localparam logic [K_W-1:0] RECIP_K_V = K_W'(RECIP_K_L);

    // Mixer widths
    localparam int SH_W  = 9;         // shaped axis, signed
    localparam int MIX_W = 10;        // sum or difference, signed
    localparam int ABS_W = 9;         // magnitude of a mix, 0..260
    localparam int NUM_W = 17;        // rescale numerator
    localparam int DEN_W = 10;        // rescale denominator
    localparam int QUO_W = 7;         // rescale quotient, 0..127
    localparam logic [NUM_W-1:0] TWO_F_V = NUM_W'(2 * FULL_SCALE);
    localparam logic [ABS_W-1:0] FS_ABS  = ABS_W'(FULL_SCALE);
    localparam logic [QUO_W-1:0] FS_QUO  = QUO_W'(FULL_SCALE);

    // Register stages from input to merged result
    localparam int PIPE_DEPTH = 15;

    // One shaped axis from a lane
    typedef struct packed {
        logic             neg;
        logic             zero;
        logic [MAG_W-1:0] mag;
    } t_shaped;

    // Sideband that rides along with the rescale divider
    typedef struct packed {
        logic             scale;   // larger magnitude exceeds full scale
        logic             lbig;    // left carries the larger magnitude
        logic             sl;      // left negative
        logic             sr;      // right negative
        logic [OUT_W-1:0] l8;      // left as is, used when no scaling
        logic [OUT_W-1:0] r8;      // right as is
    } t_side;

endpackage

// ----- hdl/adm_lane.sv -----
// Axis shaper lane: deadband and cubic curve blend, five register stages.
module adm_lane
    import adm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [AXIS_W-1:0] i_axis,
    input  logic [CW_W-1:0]          i_curve,
    input  logic [DB_W-1:0]          i_deadband,
    output t_shaped                  o_shaped
);

    typedef struct packed {
        logic neg;
        logic zero;
    } t_flags;

    t_flags             r1_flg, r2_flg, r3_flg, r4_flg, r5_flg;
    logic [MAG_W-1:0]   r1_a;
    logic [A2_W-1:0]    r1_a2;
    logic [A3_W-1:0]    r2_a3;
    logic [LIN_W-1:0]   r2_lin;
    logic [PROD_W-1:0]  r3_cub, r3_lnp;
    logic [Y_W-1:0]     r4_y;
    logic [MAG_W-1:0]   r5_q;

    logic               n1_neg;
    logic [MAG_W-1:0]   n1_a;
    logic [AXIS_W-1:0]  axis_u;
    logic [2*MAG_W-1:0] sq_full;
    logic [A2_W+MAG_W-1:0] cube_full;
    logic [MAG_W+F2_W-1:0] lin_full;
    logic [CW_W-1:0]    wgt_lin;
    logic [CW_W+A3_W-1:0]  cub_full;
    logic [CW_W+LIN_W-1:0] lnp_full;
    logic [PROD_W:0]    sum;
    logic [Y_W+K_W-1:0] recip_prod;

    // Stage 1: magnitude, square, deadband test
    assign axis_u  = i_axis;
    assign n1_neg  = i_axis[AXIS_W-1];
    assign n1_a    = n1_neg ? (~axis_u + 1'b1) : axis_u;
    assign sq_full = n1_a * n1_a;

    // Stage 2: cube and linear term
    assign cube_full = r1_a2 * r1_a;
    assign lin_full  = r1_a * F2_V;

    // Stage 3: blend weights
    assign wgt_lin  = CW_ONE - i_curve;
    assign cub_full = i_curve * r2_a3;
    assign lnp_full = wgt_lin * r2_lin;

    // Stage 4: sum, round offset, drop the weight scale
    assign sum = {1'b0, r3_cub} + {1'b0, r3_lnp} + HALF_DEN_V;

    // Stage 5: divide by F^2 through the exact reciprocal
    assign recip_prod = r4_y * RECIP_K_V;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_flg.neg  <= n1_neg;
            r1_flg.zero <= n1_a < i_deadband;
            r1_a        <= n1_a;
            r1_a2       <= sq_full[A2_W-1:0];

            r2_flg      <= r1_flg;
            r2_a3       <= cube_full[A3_W-1:0];
            r2_lin      <= lin_full[LIN_W-1:0];

            r3_flg      <= r2_flg;
            r3_cub      <= cub_full[PROD_W-1:0];
            r3_lnp      <= lnp_full[PROD_W-1:0];

            r4_flg      <= r3_flg;
            r4_y        <= sum[SHAPE_SHIFT +: Y_W];

            r5_flg      <= r4_flg;
            r5_q        <= recip_prod[RECIP_S +: MAG_W];
        end
    end

    assign o_shaped.neg  = r5_flg.neg;
    assign o_shaped.zero = r5_flg.zero;
    assign o_shaped.mag  = r5_q;

endmodule

// ----- hdl/adm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module adm_div
    import adm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    localparam int STEPS = QUO_W;

    logic [NUM_W-1:0] r_rem [STEPS-1];
    logic [DEN_W-1:0] r_den [STEPS-1];
    logic [QUO_W-1:0] r_quo [STEPS];

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        localparam int K = STEPS - 1 - s;

        logic [NUM_W-1:0] in_rem;
        logic [DEN_W-1:0] in_den;
        logic [QUO_W-1:0] in_quo;
        logic [NUM_W-1:0] trial;
        logic             ge;
        logic [QUO_W-1:0] n_quo;

        if (s == 0) begin : g_first
            assign in_rem = i_num;
            assign in_den = i_den;
            assign in_quo = '0;
        end else begin : g_next
            assign in_rem = r_rem[s-1];
            assign in_den = r_den[s-1];
            assign in_quo = r_quo[s-1];
        end

        // compare against the shifted divisor, subtract when it fits
        assign trial = NUM_W'(in_den) << K;
        assign ge    = in_rem >= trial;

        always_comb begin
            n_quo    = in_quo;
            n_quo[K] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[s] <= n_quo;
            end
        end

        if (s < STEPS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= ge ? (in_rem - trial) : in_rem;
                    r_den[s] <= in_den;
                end
            end
        end
    end

    assign o_quo = r_quo[STEPS-1];

endmodule

// ----- hdl/adm_merge.sv -----
// Merge stage: arcade mix of the two shaped axes and full-scale normalization.
module adm_merge
    import adm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  t_shaped                 i_thr,
    input  t_shaped                 i_trn,
    output logic signed [OUT_W-1:0] o_left,
    output logic signed [OUT_W-1:0] o_right
);

    localparam int STEPS = QUO_W;

    logic signed [MIX_W-1:0] r_l, r_r;
    logic [NUM_W-1:0]        r_num;
    logic [DEN_W-1:0]        r_den;
    t_side                   r_side_m2;
    t_side                   r_side [STEPS];
    logic signed [OUT_W-1:0] r_left, r_right;

    logic signed [SH_W-1:0]  t_val, u_val;
    logic [ABS_W-1:0]        al, ar, m, sm;
    logic                    lbig;
    t_side                   n_side;
    logic [QUO_W-1:0]        quo;
    t_side                   fin;
    logic [QUO_W-1:0]        mag_l, mag_r;
    logic [OUT_W-1:0]        ml8, mr8, n_left, n_right;

    function automatic logic signed [SH_W-1:0] axis_val(input t_shaped s);
        logic signed [SH_W-1:0] v;
        v = $signed({1'b0, s.mag});
        if (s.zero) begin
            return '0;
        end
        return s.neg ? -v : v;
    endfunction

    // M1: signed shaped axes, sum and difference
    assign t_val = axis_val(i_thr);
    assign u_val = axis_val(i_trn);

    // M2: magnitudes, larger and smaller, rescale operands
    assign al   = ABS_W'(r_l[MIX_W-1] ? -r_l : r_l);
    assign ar   = ABS_W'(r_r[MIX_W-1] ? -r_r : r_r);
    assign lbig = al >= ar;
    assign m    = lbig ? al : ar;
    assign sm   = lbig ? ar : al;

    always_comb begin
        n_side.scale = m > FS_ABS;
        n_side.lbig  = lbig;
        n_side.sl    = r_l[MIX_W-1];
        n_side.sr    = r_r[MIX_W-1];
        n_side.l8    = r_l[OUT_W-1:0];
        n_side.r8    = r_r[OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l       <= MIX_W'(t_val) + MIX_W'(u_val);
            r_r       <= MIX_W'(t_val) - MIX_W'(u_val);
            // round(sm*F/m) = floor((2*F*sm + m) / (2*m))
            r_num     <= NUM_W'(sm) * TWO_F_V + NUM_W'(m);
            r_den     <= {m, 1'b0};
            r_side_m2 <= n_side;
        end
    end

    adm_div u_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_num),
        .i_den (r_den),
        .o_quo (quo)
    );

    // sideband delay matching the divider
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= r_side_m2;
            for (int i = 1; i < STEPS; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // M3: when scaling, larger side lands on full scale, smaller on the quotient; else pass through
    assign fin   = r_side[STEPS-1];
    assign mag_l = fin.lbig ? FS_QUO : quo;
    assign mag_r = fin.lbig ? quo : FS_QUO;
    assign ml8   = {1'b0, mag_l};
    assign mr8   = {1'b0, mag_r};

    always_comb begin
        if (fin.scale) begin
            n_left  = fin.sl ? (~ml8 + 1'b1) : ml8;
            n_right = fin.sr ? (~mr8 + 1'b1) : mr8;
        end else begin
            n_left  = fin.l8;
            n_right = fin.r8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

// ----- hdl/arcade_drive_mixer_core.sv -----
// Arcade drive mixer top level: config registers, two shaper lanes, merge, output buffer.
//
//  channel   direction  handshake             words
//  input     in         i_valid / o_ready     i_throttle, i_turn
//  output    out        o_valid / i_ready     o_left_power, o_right_power
//  config    in         i_cfg_we              i_cfg_index, i_cfg_data
//
// One word pair enters per cycle while the skid entry is empty; a result leaves
// through the 15-stage datapath (5 shaper stages, 2 mix stages,
// 7 divider stages, 1 final stage) and then the output register.
// Reset (synchronous, active low) empties the pipe and sets both registers to 0.
// A stalled output fills one skid entry; the pipe then holds until it drains.
module arcade_drive_mixer_core
    import adm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DAT_W-1:0]     i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [AXIS_W-1:0] i_throttle,
    input  logic signed [AXIS_W-1:0] i_turn,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [OUT_W-1:0]  o_left_power,
    output logic signed [OUT_W-1:0]  o_right_power
);

    logic [CW_W-1:0]         r_curve_weight;
    logic [DB_W-1:0]         r_deadband;
    logic [PIPE_DEPTH-1:0]   r_vld;
    logic                    r_o_valid, r_sk_valid;
    logic signed [OUT_W-1:0] r_o_left, r_o_right, r_sk_left, r_sk_right;

    logic                    en, push, pop;
    logic [CW_W-1:0]         curve_sat;
    t_shaped                 thr_sh, trn_sh;
    logic signed [OUT_W-1:0] mix_left, mix_right;

    // Config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_weight <= '0;
            r_deadband     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CURVE_WEIGHT: r_curve_weight <= i_cfg_data;
                REG_DEADBAND:     r_deadband     <= i_cfg_data[DB_W-1:0];
                default:          ;
            endcase
        end
    end

    // weight above 1.0 clamps to fully cubic
    assign curve_sat = (r_curve_weight > CW_ONE) ? CW_ONE : r_curve_weight;

    // Pipe advances unless the skid entry is occupied
    assign en      = !r_sk_valid;
    assign o_ready = en;
    assign push    = en && r_vld[PIPE_DEPTH-1];
    assign pop     = r_o_valid && i_ready;

    adm_lane u_lane_thr (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_axis     (i_throttle),
        .i_curve    (curve_sat),
        .i_deadband (r_deadband),
        .o_shaped   (thr_sh)
    );

    adm_lane u_lane_trn (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_axis     (i_turn),
        .i_curve    (curve_sat),
        .i_deadband (r_deadband),
        .o_shaped   (trn_sh)
    );

    adm_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_thr   (thr_sh),
        .i_trn   (trn_sh),
        .o_left  (mix_left),
        .o_right (mix_right)
    );

    // Valid tracking and output/skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_o_valid  <= 1'b0;
            r_sk_valid <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
            end
            if (!r_o_valid || pop) begin
                if (r_sk_valid) begin
                    r_o_valid  <= 1'b1;
                    r_sk_valid <= 1'b0;
                end else begin
                    r_o_valid  <= push;
                end
            end else if (push) begin
                r_sk_valid <= 1'b1;
            end
        end
    end

    // Output and skid words
    always_ff @(posedge i_clk) begin
        if (!r_o_valid || pop) begin
            if (r_sk_valid) begin
                r_o_left  <= r_sk_left;
                r_o_right <= r_sk_right;
            end else if (push) begin
                r_o_left  <= mix_left;
                r_o_right <= mix_right;
            end
        end else if (push) begin
            r_sk_left  <= mix_left;
            r_sk_right <= mix_right;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_left_power  = r_o_left;
    assign o_right_power = r_o_right;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_o_valid)
        else $error("skid entry held without an output word");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_valid) |-> $past(r_o_valid && !i_ready))
        else $error("skid entry filled while output was free");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_left_power != -8'sd128) && (o_right_power != -8'sd128))
        else $error("motor command outside full scale");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sk_valid && !i_ready) |=> $stable(r_vld))
        else $error("pipe moved while output buffer was full");
`endif

endmodule
